/* rtl/core/g2o_pkg.sv */
// Shared types, constants and helper functions for the glyph to gray display writer.
package g2o_pkg;

    // One byte of the font store and of the SPI stream.
    typedef logic [7:0] byte_t;

    // Position of a byte within the 22-byte sequence of one plot.
    typedef logic [4:0] emit_idx_t;

    // Function codes of an input item.
    localparam logic FUNC_PLOT = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INK     = 2'd0;
    localparam logic [1:0] CFG_PAPER   = 2'd1;
    localparam logic [1:0] CFG_INVERSE = 2'd2;
    localparam logic [1:0] CFG_START   = 2'd3;

    // Sequence layout of one plot.
    localparam int GLYPH_BYTES = 4;
    localparam int PLOT_BYTES  = 22;
    localparam int CMD_BYTES   = 6;

    localparam emit_idx_t IDX_COL_CMD   = 5'd0;
    localparam emit_idx_t IDX_COL_START = 5'd1;
    localparam emit_idx_t IDX_COL_END   = 5'd2;
    localparam emit_idx_t IDX_ROW_CMD   = 5'd3;
    localparam emit_idx_t IDX_ROW_START = 5'd4;
    localparam emit_idx_t IDX_ROW_END   = 5'd5;
    localparam emit_idx_t IDX_FIRST_DATA = 5'd6;
    localparam emit_idx_t IDX_LAST      = 5'd21;
    // Glyph byte i is fetched while byte 5+4i is generated.
    localparam emit_idx_t IDX_FIRST_READ = 5'd5;
    localparam emit_idx_t IDX_LAST_READ  = 5'd17;
    // From this index on, the font store is no longer read for the current plot.
    localparam emit_idx_t IDX_READS_DONE = 5'd18;

    // Controller command codes.
    localparam byte_t CMD_COL_WINDOW = 8'h21;
    localparam byte_t CMD_ROW_WINDOW = 8'h22;

    // Printable character range.
    localparam byte_t CODE_FIRST = 8'd32;
    localparam byte_t CODE_LAST  = 8'd126;

    // Gray pair bytes.
    localparam byte_t GRAY_OFF    = 8'h00;
    localparam byte_t GRAY_DIM    = 8'h88;
    localparam byte_t GRAY_BRIGHT = 8'hff;

    // Glyph shown for codes that have no font entry.
    localparam byte_t BAD_GLYPH [GLYPH_BYTES] = '{8'h0e, 8'haa, 8'haa, 8'hae};

    // Per-plot context held by the emitter.
    typedef struct packed {
        byte_t      x;
        byte_t      y;
        logic       chip;
        byte_t      ink;
        byte_t      paper;
        logic       bad;
        logic [7:0] glyph;
    } plot_ctx_t;

    // Gray pair byte for an attribute: off when the low three bits are zero.
    function automatic byte_t attr_gray(input logic [3:0] a);
        byte_t g;
        if (a[2:0] == 3'b000)
        begin
            g = GRAY_OFF;
        end
        else if (a[3])
        begin
            g = GRAY_BRIGHT;
        end
        else
        begin
            g = GRAY_DIM;
        end
        return g;
    endfunction

endpackage

/* rtl/core/glyph_to_gray_oled_writer_top.sv */
// Top level of the glyph to gray display writer: item queue, byte emitter, config registers.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_ready  | func, text_row, text_col, char_code, font_addr,
//          |                      | font_byte
//  out     | out_valid / out_ready| spi_byte, is_data, chip_sel, last_byte
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A plot is 22 SPI bytes, sent one SPI byte per cycle while out_ready is high, and plots
// follow each other with no gap; the emitter's byte counter and the single font store
// read port set this. A font load is written from the head of the item queue once the
// emitter has finished reading glyph bytes for the plot in flight.
// Reset clears the control state and the configuration; the font store is not cleared.
// Low out_ready freezes the emitter; the input register keeps accepting one item ahead.
module glyph_to_gray_oled_writer_top #(
    parameter int TEXT_COLUMNS  = 80,
    parameter int COLUMN_BYTES  = 80,
    parameter int SEGMENT_LINES = 160,
    parameter int GLYPH_COUNT   = 96
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [4:0]  text_row,
    input  logic [6:0]  text_col,
    input  logic [7:0]  char_code,
    input  logic [8:0]  font_addr,
    input  logic [7:0]  font_byte,
    // Result bytes
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  spi_byte,
    output logic        is_data,
    output logic        chip_sel,
    output logic        last_byte,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int STORE_DEPTH = GLYPH_COUNT * g2o_pkg::GLYPH_BYTES;
    localparam int AW          = $clog2(STORE_DEPTH);

    // Column start address of a text column.
    function automatic g2o_pkg::byte_t col_x(input logic [6:0] c);
        g2o_pkg::byte_t r;
        r = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (c == 7'(i))
            begin
                r = 8'((2 * i) % COLUMN_BYTES);
            end
        end
        return r;
    endfunction

    // Segment line of a text row, before the start line offset.
    function automatic g2o_pkg::byte_t row_y(input logic [4:0] r);
        g2o_pkg::byte_t v;
        v = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (r == 5'(i))
            begin
                v = 8'((8 * i) % SEGMENT_LINES);
            end
        end
        return v;
    endfunction

    // Start line offset reduced to the segment range.
    function automatic g2o_pkg::byte_t line_mod(input logic [7:0] s);
        g2o_pkg::byte_t v;
        v = '0;
        for (int i = 0; i < 256; i++)
        begin
            if (s == 8'(i))
            begin
                v = 8'(i % SEGMENT_LINES);
            end
        end
        return v;
    endfunction

    // Configuration registers.
    logic [3:0]     ink_attr_reg;
    logic [3:0]     paper_attr_reg;
    logic           inverse_reg;
    g2o_pkg::byte_t start_mod_reg;

    // Input holding register.
    logic           head_valid_reg;
    logic           head_func_reg;
    logic [4:0]     head_row_reg;
    logic [6:0]     head_col_reg;
    logic [7:0]     head_code_reg;
    logic [8:0]     head_faddr_reg;
    logic [7:0]     head_fbyte_reg;

    // Emitter state.
    logic                 busy_reg;
    g2o_pkg::emit_idx_t   idx_reg;
    g2o_pkg::plot_ctx_t   ctx_reg;
    g2o_pkg::plot_ctx_t   ctx_next;

    // Output register.
    logic           out_valid_reg;
    g2o_pkg::byte_t spi_byte_reg;
    logic           is_data_reg;
    logic           chip_sel_reg;
    logic           last_byte_reg;

    logic           advance;
    logic           gen_last;
    logic           emit_free;
    logic           start;
    logic           do_load;
    logic           load_ok;
    logic           head_take;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    g2o_pkg::byte_t rd_data;

    // Configuration port takes a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ink_attr_reg   <= 4'd7;
            paper_attr_reg <= 4'd0;
            inverse_reg    <= 1'b0;
            start_mod_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                g2o_pkg::CFG_INK:     ink_attr_reg   <= cfg_data[3:0];
                g2o_pkg::CFG_PAPER:   paper_attr_reg <= cfg_data[3:0];
                g2o_pkg::CFG_INVERSE: inverse_reg    <= cfg_data[0];
                g2o_pkg::CFG_START:   start_mod_reg  <= line_mod(cfg_data);
                default:              ;
            endcase
        end
    end

    // Dispatch decisions for the item at the head of the queue.
    assign advance   = !out_valid_reg || out_ready;
    assign gen_last  = busy_reg && (idx_reg == g2o_pkg::IDX_LAST);
    assign emit_free = !busy_reg || (advance && gen_last);
    assign load_ok   = !busy_reg || (idx_reg >= g2o_pkg::IDX_READS_DONE);
    assign start     = head_valid_reg && (head_func_reg == g2o_pkg::FUNC_PLOT) && emit_free;
    assign do_load   = head_valid_reg && (head_func_reg == g2o_pkg::FUNC_LOAD) && load_ok;
    assign head_take = start || do_load;
    assign in_ready  = !head_valid_reg || head_take;

    // Input holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            head_valid_reg <= 1'b1;
        end
        else if (head_take)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            head_func_reg  <= func;
            head_row_reg   <= text_row;
            head_col_reg   <= text_col;
            head_code_reg  <= char_code;
            head_faddr_reg <= font_addr;
            head_fbyte_reg <= font_byte;
        end
    end

    // Font store write; addresses beyond the store are dropped.
    logic [10:0] faddr_wide;
    assign faddr_wide = {2'b00, head_faddr_reg};
    assign wr_en      = do_load && (faddr_wide < 11'(STORE_DEPTH));
    assign wr_addr    = faddr_wide[AW-1:0];

    // Plot context built from the head item and the configuration.
    logic [7:0]     glyph_num;
    logic [8:0]     y_sum;
    logic [8:0]     y_wrap;
    g2o_pkg::byte_t ink_gray;
    g2o_pkg::byte_t paper_gray;

    always_comb
    begin
        ink_gray   = g2o_pkg::attr_gray(ink_attr_reg);
        paper_gray = g2o_pkg::attr_gray(paper_attr_reg);
        glyph_num  = head_code_reg - g2o_pkg::CODE_FIRST;
        y_sum      = {1'b0, row_y(head_row_reg)} + {1'b0, start_mod_reg};
        y_wrap     = (y_sum >= 9'(SEGMENT_LINES)) ? (y_sum - 9'(SEGMENT_LINES)) : y_sum;

        ctx_next.x     = col_x(head_col_reg);
        ctx_next.y     = y_wrap[7:0];
        ctx_next.chip  = !({1'b0, head_col_reg} < 8'(TEXT_COLUMNS / 2));
        ctx_next.ink   = inverse_reg ? paper_gray : ink_gray;
        ctx_next.paper = inverse_reg ? ink_gray : paper_gray;
        ctx_next.bad   = !((head_code_reg inside {[g2o_pkg::CODE_FIRST:g2o_pkg::CODE_LAST]})
                          && ({1'b0, glyph_num} < 9'(GLYPH_COUNT)));
        ctx_next.glyph = ctx_next.bad ? 8'd0 : glyph_num;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Emitter control: byte counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance && gen_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance && busy_reg)
            begin
                idx_reg <= idx_reg + 5'd1;
            end

            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    // Glyph byte fetch, one every four data bytes, a byte ahead of its use.
    g2o_pkg::emit_idx_t rd_rel;
    logic [10:0]        rd_addr_wide;

    assign rd_rel       = idx_reg - g2o_pkg::IDX_FIRST_READ;
    assign rd_en        = advance && busy_reg && (idx_reg[1:0] == 2'b01)
                          && (idx_reg inside {[g2o_pkg::IDX_FIRST_READ:g2o_pkg::IDX_LAST_READ]});
    assign rd_addr_wide = {1'b0, ctx_reg.glyph, rd_rel[3:2]};
    assign rd_addr      = rd_addr_wide[AW-1:0];

    g2o_font_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_font_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (head_fbyte_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Byte generation for the current index.
    g2o_pkg::emit_idx_t data_rel;
    g2o_pkg::byte_t     glyph_byte;
    logic [3:0]         nib;
    g2o_pkg::byte_t     mask;
    g2o_pkg::byte_t     pix_byte;
    g2o_pkg::byte_t     gen_byte;

    always_comb
    begin
        data_rel   = idx_reg - g2o_pkg::IDX_FIRST_DATA;
        glyph_byte = ctx_reg.bad ? g2o_pkg::BAD_GLYPH[data_rel[3:2]] : rd_data;
        nib        = data_rel[1] ? glyph_byte[3:0] : glyph_byte[7:4];
        mask       = data_rel[0] ? {{4{nib[0]}}, {4{nib[1]}}} : {{4{nib[2]}}, {4{nib[3]}}};
        pix_byte   = (~mask & ctx_reg.paper) | (mask & ctx_reg.ink);

        case (idx_reg)
            g2o_pkg::IDX_COL_CMD:   gen_byte = g2o_pkg::CMD_COL_WINDOW;
            g2o_pkg::IDX_COL_START: gen_byte = ctx_reg.x;
            g2o_pkg::IDX_COL_END:   gen_byte = ctx_reg.x + 8'd1;
            g2o_pkg::IDX_ROW_CMD:   gen_byte = g2o_pkg::CMD_ROW_WINDOW;
            g2o_pkg::IDX_ROW_START: gen_byte = ctx_reg.y;
            g2o_pkg::IDX_ROW_END:   gen_byte = 8'(SEGMENT_LINES - 1);
            default:                gen_byte = pix_byte;
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (advance && busy_reg)
        begin
            spi_byte_reg  <= gen_byte;
            is_data_reg   <= (idx_reg >= g2o_pkg::IDX_FIRST_DATA);
            chip_sel_reg  <= ctx_reg.chip;
            last_byte_reg <= (idx_reg == g2o_pkg::IDX_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign spi_byte  = spi_byte_reg;
    assign is_data   = is_data_reg;
    assign chip_sel  = chip_sel_reg;
    assign last_byte = last_byte_reg;

    // The closing byte of a plot is always a pixel byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_byte) |-> is_data)
        else $error("last byte of a plot is not a data byte");

    // After the closing byte, the next byte shown starts a new command window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte) |=> (!out_valid || !is_data))
        else $error("plot did not restart with command bytes");

    // Within a plot the bytes keep coming and the chip side does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_byte) |=> (out_valid && $stable(chip_sel)))
        else $error("plot sequence broken or chip side changed");

    // The font store is not overwritten while the current plot still reads it.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!busy_reg || (idx_reg >= g2o_pkg::IDX_READS_DONE)))
        else $error("font write during glyph fetch");

endmodule

/* rtl/core/g2o_font_mem.sv */
// Font store: single write port, single registered read port.
module g2o_font_mem #(
    parameter int DEPTH = 384,
    parameter int AW    = 9
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  g2o_pkg::byte_t  wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output g2o_pkg::byte_t  rd_data
);

    g2o_pkg::byte_t mem [DEPTH];
    g2o_pkg::byte_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; a read in the same cycle as a write sees the old byte.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sim/tb_glyph_to_gray_oled_writer_top.sv */
// Self-checking testbench for the glyph to gray display writer, with its own byte predictor.
`timescale 1ns / 100ps

module tb_glyph_to_gray_oled_writer_top;

    localparam int TEXT_COLUMNS  = 80;
    localparam int COLUMN_BYTES  = 80;
    localparam int SEGMENT_LINES = 160;
    localparam int GLYPH_COUNT   = 96;
    localparam int FONT_DEPTH    = GLYPH_COUNT * 4;

    localparam int CLK_PERIOD    = 20;
    localparam int IDLE_PERCENT  = 31;
    localparam int TAIL_CYCLES   = 2 * g2o_pkg::PLOT_BYTES + 10;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASE_ITEMS   = 15;
    localparam int DIRECTED_ROWS = 25;

    // Glyph drawn for codes that have no font entry.
    localparam logic [7:0] INVALID_GLYPH [4] = '{8'h0e, 8'haa, 8'haa, 8'hae};

    typedef struct packed {
        logic       func;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] code;
        logic [8:0] addr;
        logic [7:0] fbyte;
    } glyph_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_data;
        logic       chip;
        logic       last;
    } spi_word_t;

    // One row of the directed table; window start and chip are typed in where marked.
    typedef struct packed {
        glyph_req_t req;
        logic       typed;
        logic [7:0] x_exp;
        logic [7:0] y_exp;
        logic       chip_exp;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Glyph for 'A', then space, then tilde.
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd132, 8'h96}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd133, 8'h69}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd134, 8'hf0}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd135, 8'h0f}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd0,   8'h00}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd1,   8'hff}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd2,   8'ha5}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd3,   8'h5a}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd376, 8'h81}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd377, 8'h42}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd378, 8'h24}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd379, 8'h18}, 1'b0, 8'd0, 8'd0, 1'b0},
        // Last store entry, then two addresses past the end that must be dropped.
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd383, 8'h7e}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd384, 8'h33}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_LOAD, 5'd31, 7'd127, 8'd255, 9'd511, 8'hcc},
          1'b0, 8'd0, 8'd0, 1'b0},
        // Plots at the corners of the screen and past them.
        '{'{g2o_pkg::FUNC_PLOT, 5'd0,  7'd0,   8'd65,  9'd0, 8'd0}, 1'b1, 8'd0,  8'd0,   1'b0},
        '{'{g2o_pkg::FUNC_PLOT, 5'd19, 7'd79,  8'd32,  9'd0, 8'd0}, 1'b1, 8'd78, 8'd152, 1'b1},
        '{'{g2o_pkg::FUNC_PLOT, 5'd0,  7'd39,  8'd126, 9'd0, 8'd0}, 1'b1, 8'd78, 8'd0,   1'b0},
        '{'{g2o_pkg::FUNC_PLOT, 5'd1,  7'd40,  8'd126, 9'd0, 8'd0}, 1'b1, 8'd0,  8'd8,   1'b1},
        // Unprintable codes use the fixed glyph.
        '{'{g2o_pkg::FUNC_PLOT, 5'd31, 7'd127, 8'd0,   9'h1ff, 8'hff},
          1'b1, 8'd14, 8'd88, 1'b1},
        '{'{g2o_pkg::FUNC_PLOT, 5'd20, 7'd80,  8'd127, 9'd0, 8'd0}, 1'b1, 8'd0,  8'd0,   1'b1},
        '{'{g2o_pkg::FUNC_PLOT, 5'd5,  7'd10,  8'd255, 9'd0, 8'd0}, 1'b1, 8'd20, 8'd40,  1'b0},
        '{'{g2o_pkg::FUNC_PLOT, 5'd2,  7'd3,   8'd31,  9'd0, 8'd0}, 1'b1, 8'd6,  8'd16,  1'b0},
        // Rewrite one glyph byte and plot it again.
        '{'{g2o_pkg::FUNC_LOAD, 5'd0, 7'd0, 8'd0, 9'd134, 8'h3c}, 1'b0, 8'd0, 8'd0, 1'b0},
        '{'{g2o_pkg::FUNC_PLOT, 5'd7,  7'd50,  8'd65,  9'd0, 8'd0}, 1'b1, 8'd20, 8'd56,  1'b1}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       func;
    logic [4:0] text_row;
    logic [6:0] text_col;
    logic [7:0] char_code;
    logic [8:0] font_addr;
    logic [7:0] font_byte;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] spi_byte;
    logic       is_data;
    logic       chip_sel;
    logic       last_byte;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Predictor state: font image, which entries hold data, and the registers.
    logic [7:0]  font_img [FONT_DEPTH];
    logic        font_written [FONT_DEPTH];
    logic [3:0]  ink_code;
    logic [3:0]  paper_code;
    logic        swap_gray;
    logic [7:0]  line_offset;

    spi_word_t   spi_q [$];
    spi_word_t   spi_want;
    int unsigned error_count = 0;
    logic        steady = 1'b0;

    glyph_to_gray_oled_writer_top #(
        .TEXT_COLUMNS  (TEXT_COLUMNS),
        .COLUMN_BYTES  (COLUMN_BYTES),
        .SEGMENT_LINES (SEGMENT_LINES),
        .GLYPH_COUNT   (GLYPH_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .text_row  (text_row),
        .text_col  (text_col),
        .char_code (char_code),
        .font_addr (font_addr),
        .font_byte (font_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .spi_byte  (spi_byte),
        .is_data   (is_data),
        .chip_sel  (chip_sel),
        .last_byte (last_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // 4-bit gray level of an attribute: dark when the color bits are clear.
    function automatic logic [3:0] gray_level(input logic [3:0] attr);
        if (attr[2:0] == 3'd0)
        begin
            return 4'h0;
        end
        return attr[3] ? 4'hf : 4'h8;
    endfunction

    function automatic logic glyph_loaded(input int unsigned glyph);
        return font_written[glyph * 4] && font_written[glyph * 4 + 1] &&
               font_written[glyph * 4 + 2] && font_written[glyph * 4 + 3];
    endfunction

    // Works out the 22 SPI bytes that one plot produces.
    function automatic void plot_sequence(input glyph_req_t req,
                                          output spi_word_t seq [g2o_pkg::PLOT_BYTES]);
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic [3:0]  nib;
        logic [7:0]  cells [4];
        logic [7:0]  x;
        logic        chip;
        int unsigned colv;
        int unsigned rowv;
        int unsigned base;
        fg = gray_level(ink_code);
        bg = gray_level(paper_code);
        if (swap_gray)
        begin
            fg = gray_level(paper_code);
            bg = gray_level(ink_code);
        end
        if ((req.code inside {[8'd32:8'd126]}) && (req.code - 32) < GLYPH_COUNT)
        begin
            base = (req.code - 32) * 4;
            for (int i = 0; i < 4; i++)
            begin
                cells[i] = font_img[base + i];
            end
        end
        else
        begin
            cells = INVALID_GLYPH;
        end
        colv = req.col;
        rowv = req.row;
        x = 8'((colv * 2) % COLUMN_BYTES);
        chip = (colv < TEXT_COLUMNS / 2) ? 1'b0 : 1'b1;
        seq[0].data = g2o_pkg::CMD_COL_WINDOW;
        seq[1].data = x;
        seq[2].data = x + 8'd1;
        seq[3].data = g2o_pkg::CMD_ROW_WINDOW;
        seq[4].data = 8'((rowv * 8 + line_offset) % SEGMENT_LINES);
        seq[5].data = 8'(SEGMENT_LINES - 1);
        // Each nibble gives two bytes; the left pixel sits in the low half of a byte.
        for (int i = 0; i < 4; i++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                nib = (h == 0) ? cells[i][7:4] : cells[i][3:0];
                seq[g2o_pkg::CMD_BYTES + i * 4 + h * 2].data =
                    {nib[2] ? fg : bg, nib[3] ? fg : bg};
                seq[g2o_pkg::CMD_BYTES + i * 4 + h * 2 + 1].data =
                    {nib[0] ? fg : bg, nib[1] ? fg : bg};
            end
        end
        for (int k = 0; k < g2o_pkg::PLOT_BYTES; k++)
        begin
            seq[k].is_data = (k >= g2o_pkg::CMD_BYTES);
            seq[k].chip    = chip;
            seq[k].last    = (k == g2o_pkg::PLOT_BYTES - 1);
        end
    endfunction

    // Presents one item and updates the predictor once the transfer happens.
    task automatic send_item(input glyph_req_t req, input logic typed,
                             input logic [7:0] x_exp, input logic [7:0] y_exp,
                             input logic chip_exp);
        spi_word_t seq [g2o_pkg::PLOT_BYTES];
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= req.func;
        text_row  <= req.row;
        text_col  <= req.col;
        char_code <= req.code;
        font_addr <= req.addr;
        font_byte <= req.fbyte;
        do @(posedge clk); while (!in_ready);
        if (req.func == g2o_pkg::FUNC_LOAD)
        begin
            if (req.addr < FONT_DEPTH)
            begin
                font_img[req.addr]     = req.fbyte;
                font_written[req.addr] = 1'b1;
            end
        end
        else
        begin
            plot_sequence(req, seq);
            // Typed-in window starts and chip select stand in for the predicted ones.
            if (typed)
            begin
                seq[1].data = x_exp;
                seq[4].data = y_exp;
                for (int k = 0; k < g2o_pkg::PLOT_BYTES; k++)
                begin
                    seq[k].chip = chip_exp;
                end
            end
            for (int k = 0; k < g2o_pkg::PLOT_BYTES; k++)
            begin
                spi_q.push_back(seq[k]);
            end
        end
    endtask

    // Random traffic: glyph loads followed by plots of loaded glyphs, plus noise.
    task automatic random_traffic(input int unsigned count);
        glyph_req_t  req;
        int unsigned sent;
        int unsigned pick;
        int unsigned glyph;
        int unsigned pool [$];
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            req.code  = 8'($urandom);
            req.addr  = 9'($urandom);
            req.fbyte = 8'($urandom);
            req.row   = 5'($urandom);
            req.col   = 7'($urandom);
            if (pick < 15)
            begin
                glyph = $urandom_range(0, GLYPH_COUNT - 1);
                req.func = g2o_pkg::FUNC_LOAD;
                for (int k = 0; k < 4; k++)
                begin
                    req.addr  = 9'(glyph * 4 + k);
                    req.fbyte = 8'($urandom);
                    send_item(req, 1'b0, 8'd0, 8'd0, 1'b0);
                end
                sent += 4;
            end
            else if (pick < 25)
            begin
                req.func = g2o_pkg::FUNC_LOAD;
                send_item(req, 1'b0, 8'd0, 8'd0, 1'b0);
                sent++;
            end
            else
            begin
                req.func = g2o_pkg::FUNC_PLOT;
                pool.delete();
                for (int g = 0; g < GLYPH_COUNT && g < 95; g++)
                begin
                    if (glyph_loaded(g))
                    begin
                        pool.push_back(g);
                    end
                end
                if (pool.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    req.code = 8'(pool[$urandom_range(0, pool.size() - 1)] + 32);
                end
                else
                begin
                    pick = $urandom_range(0, 160);
                    req.code = (pick < 32) ? 8'(pick) : 8'(pick + 95);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    req.row = 5'($urandom_range(0, 19));
                    req.col = 7'($urandom_range(0, 79));
                end
                send_item(req, 1'b0, 8'd0, 8'd0, 1'b0);
                sent++;
            end
        end
    endtask

    // Writes one register and mirrors it in the predictor on the transfer.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            g2o_pkg::CFG_INK:     ink_code    = value[3:0];
            g2o_pkg::CFG_PAPER:   paper_code  = value[3:0];
            g2o_pkg::CFG_INVERSE: swap_gray   = value[0];
            g2o_pkg::CFG_START:   line_offset = value;
            default:              ;
        endcase
    endtask

    task automatic set_config(input logic [3:0] ink, input logic [3:0] paper,
                              input logic inv, input logic [7:0] start);
        write_reg(g2o_pkg::CFG_INK, {4'($urandom), ink});
        write_reg(g2o_pkg::CFG_PAPER, {4'($urandom), paper});
        write_reg(g2o_pkg::CFG_INVERSE, {7'($urandom), inv});
        write_reg(g2o_pkg::CFG_START, start);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Holds off the sender until every expected byte has come and the block is quiet.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (spi_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Receiver stalls at random except during the steady phase.
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compares each transferred byte with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (spi_q.size() == 0)
            begin
                $error("spi_byte: no byte expected, got %h", spi_byte);
                error_count++;
            end
            else
            begin
                spi_want = spi_q.pop_front();
                if (spi_byte !== spi_want.data)
                begin
                    $error("spi_byte: expected %h, got %h", spi_want.data, spi_byte);
                    error_count++;
                end
                if (is_data !== spi_want.is_data)
                begin
                    $error("is_data: expected %b, got %b", spi_want.is_data, is_data);
                    error_count++;
                end
                if (chip_sel !== spi_want.chip)
                begin
                    $error("chip_sel: expected %b, got %b", spi_want.chip, chip_sel);
                    error_count++;
                end
                if (last_byte !== spi_want.last)
                begin
                    $error("last_byte: expected %b, got %b", spi_want.last, last_byte);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then phases of random traffic per setting.
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = g2o_pkg::FUNC_PLOT;
        text_row  = '0;
        text_col  = '0;
        char_code = '0;
        font_addr = '0;
        font_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = g2o_pkg::CFG_INK;
        cfg_data  = '0;
        ink_code    = 4'd7;
        paper_code  = 4'd0;
        swap_gray   = 1'b0;
        line_offset = 8'd0;
        for (int a = 0; a < FONT_DEPTH; a++)
        begin
            font_img[a]     = 8'd0;
            font_written[a] = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_item(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].x_exp,
                      DIRECTED[r].y_exp, DIRECTED[r].chip_exp);
        end
        random_traffic(PHASE_ITEMS);
        wait_idle();

        // Bright ink on dark paper, last segment line as offset.
        set_config(4'hf, 4'h0, 1'b0, 8'd159);
        random_traffic(PHASE_ITEMS);
        wait_idle();

        // Ink with no color bits, inverted, offset at its top value.
        set_config(4'h8, 4'hf, 1'b1, 8'd255);
        random_traffic(PHASE_ITEMS);
        wait_idle();

        // Both sides run without idling here.
        steady = 1'b1;
        set_config(4'h0, 4'h7, 1'b1, 8'd0);
        random_traffic(PHASE_ITEMS);
        wait_idle();
        steady = 1'b0;

        set_config(4'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
        random_traffic(PHASE_ITEMS);
        wait_idle();

        if (error_count == 0 && spi_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            if (spi_q.size() != 0)
            begin
                $error("spi_byte: %0d expected bytes never arrived", spi_q.size());
            end
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard limit on the run.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule
